// File: rtl/sclcp_pkg.sv
// Shared types and codes for the suffix compare block.
`default_nettype none
package sclcp_pkg;

	typedef enum logic [1:0] {
		ORD_LT = 2'd0,
		ORD_EQ = 2'd1,
		ORD_GT = 2'd2
	} order_t;

	typedef enum logic [1:0] {
		REG_TOTAL_LENGTH    = 2'd0,
		REG_MAX_DEPTH       = 2'd1,
		REG_SPECIALS_EQUAL  = 2'd2,
		REG_SPECIALS_AT_ST  = 2'd3
	} reg_idx_t;

	localparam int unsigned REG_IDX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS = 32;
	localparam int unsigned CHAR_BITS = 8;
	localparam int unsigned LEN_OUT_BITS = 32;

	// Classified request as it sits in the queue (depth limit travels alongside).
	typedef struct packed {
		logic   first;
		logic   lim_zero;
		logic   spa;
		logic   spb;
		logic   lt;
		logic   gt;
		order_t start_order;
	} cls_t;

	typedef struct packed {
		logic specials_equal;
		logic specials_equal_at_start;
	} flags_t;

endpackage
`default_nettype wire

// File: rtl/suffix_compare_with_lcp.sv
// Throughput: one request per cycle unless the queue is full; the back end retires one
// queued request per cycle. A two-entry queue sits between front and back, and the
// result register parts the output. Requests that cause no result still pass the back
// end, which pops only if the result register is free or being taken. Reset clears
// config, queue and comparison state at once.
`default_nettype none
module suffix_compare_with_lcp #(
	parameter int unsigned POS_BITS      = 32,
	parameter int unsigned FIRST_SPECIAL = 254
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sclcp_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [sclcp_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire logic                                first,
	input  wire logic [31:0]                         start_a,
	input  wire logic [31:0]                         start_b,
	input  wire logic [sclcp_pkg::CHAR_BITS-1:0]     char_a,
	input  wire logic [sclcp_pkg::CHAR_BITS-1:0]     char_b,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      logic [1:0]                          order,
	output      logic [sclcp_pkg::LEN_OUT_BITS-1:0]  prefix_length
);
	import sclcp_pkg::*;

	localparam int unsigned CLS_BITS = $bits(cls_t);
	localparam int unsigned ENT_BITS = POS_BITS + CLS_BITS;

	logic [POS_BITS-1:0] total_length_q, max_depth_q;
	flags_t              flags_q;

	cls_t                f_cls, q_cls;
	logic [POS_BITS-1:0] f_limit, q_limit;
	logic                q_full, q_valid, q_pop, push;
	logic [ENT_BITS-1:0] q_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_length_q <= '0;
			max_depth_q    <= '0;
			flags_q        <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TOTAL_LENGTH:   total_length_q <= POS_BITS'(cfg_data);
				REG_MAX_DEPTH:      max_depth_q    <= POS_BITS'(cfg_data);
				REG_SPECIALS_EQUAL: flags_q.specials_equal <= cfg_data[0];
				REG_SPECIALS_AT_ST: flags_q.specials_equal_at_start <= cfg_data[0];
			endcase
		end
	end

	sclcp_front #(
		.POS_BITS      (POS_BITS),
		.FIRST_SPECIAL (FIRST_SPECIAL)
	) u_front (
		.first        (first),
		.start_a      (POS_BITS'(start_a)),
		.start_b      (POS_BITS'(start_b)),
		.char_a       (char_a),
		.char_b       (char_b),
		.total_length (total_length_q),
		.max_depth    (max_depth_q),
		.cls          (f_cls),
		.limit        (f_limit)
	);

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	sclcp_queue #(
		.WIDTH (ENT_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  ({f_limit, f_cls}),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd)
	);

	assign q_cls   = cls_t'(q_rd[CLS_BITS-1:0]);
	assign q_limit = q_rd[ENT_BITS-1:CLS_BITS];

	sclcp_back #(
		.POS_BITS (POS_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.flags         (flags_q),
		.q_valid       (q_valid),
		.q_cls         (q_cls),
		.q_limit       (q_limit),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.order         (order),
		.prefix_length (prefix_length)
	);

endmodule
`default_nettype wire

// File: rtl/sclcp_front.sv
// Front end: classifies a request and computes the depth limit for a new comparison.
`default_nettype none
module sclcp_front #(
	parameter int unsigned POS_BITS      = 32,
	parameter int unsigned FIRST_SPECIAL = 254
) (
	input  wire logic                           first,
	input  wire logic [POS_BITS-1:0]            start_a,
	input  wire logic [POS_BITS-1:0]            start_b,
	input  wire logic [sclcp_pkg::CHAR_BITS-1:0] char_a,
	input  wire logic [sclcp_pkg::CHAR_BITS-1:0] char_b,
	input  wire logic [POS_BITS-1:0]            total_length,
	input  wire logic [POS_BITS-1:0]            max_depth,
	output      sclcp_pkg::cls_t                cls,
	output      logic [POS_BITS-1:0]            limit
);
	import sclcp_pkg::*;

	localparam logic [CHAR_BITS-1:0] SPECIAL_MIN = CHAR_BITS'(FIRST_SPECIAL);

	logic [POS_BITS-1:0] rem_a, rem_b;

	function automatic logic [POS_BITS-1:0] remaining(
		input logic [POS_BITS-1:0] s,
		input logic [POS_BITS-1:0] tl,
		input logic [POS_BITS-1:0] md
	);
		logic [POS_BITS-1:0] r;
		r = (s < tl) ? (tl - s) : '0;
		if (md != '0 && r > md)
			r = md;
		return r;
	endfunction

	always_comb begin
		rem_a = remaining(start_a, total_length, max_depth);
		rem_b = remaining(start_b, total_length, max_depth);
		limit = (rem_a < rem_b) ? rem_a : rem_b;

		cls.first    = first;
		cls.lim_zero = (limit == '0);
		cls.spa      = (char_a >= SPECIAL_MIN);
		cls.spb      = (char_b >= SPECIAL_MIN);
		cls.lt       = (char_a < char_b);
		cls.gt       = (char_a > char_b);
		priority if (start_a < start_b)
			cls.start_order = ORD_LT;
		else if (start_a > start_b)
			cls.start_order = ORD_GT;
		else
			cls.start_order = ORD_EQ;
	end

endmodule
`default_nettype wire

// File: rtl/sclcp_queue.sv
// Two-entry request queue between front and back.
`default_nettype none
module sclcp_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic             rd_valid,
	output      logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rd_valid |-> !pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

// File: rtl/sclcp_back.sv
// Back end: runs the comparison state and holds the result register.
`default_nettype none
module sclcp_back #(
	parameter int unsigned POS_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sclcp_pkg::flags_t                 flags,
	input  wire logic                              q_valid,
	input  wire sclcp_pkg::cls_t                   q_cls,
	input  wire logic [POS_BITS-1:0]               q_limit,
	output      logic                              q_pop,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [1:0]                        order,
	output      logic [sclcp_pkg::LEN_OUT_BITS-1:0] prefix_length
);
	import sclcp_pkg::*;

	logic                busy_q;
	logic [POS_BITS-1:0] depth_q, limit_q;
	order_t              sorder_q;

	logic                out_valid_q;
	order_t              order_q;
	logic [POS_BITS-1:0] plen_q;

	logic                active, res, busy_n;
	logic [POS_BITS-1:0] dc, lim, dc_inc, res_len;
	order_t              so, res_ord;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	always_comb begin
		active  = q_cls.first || busy_q;
		dc      = q_cls.first ? '0 : depth_q;
		lim     = q_cls.first ? q_limit : limit_q;
		so      = q_cls.first ? q_cls.start_order : sorder_q;
		dc_inc  = dc + POS_BITS'(1);
		res     = 1'b0;
		res_ord = ORD_EQ;
		res_len = dc;
		busy_n  = active;

		if (active) begin
			priority if (q_cls.first && q_cls.lim_zero) begin
				res     = 1'b1;
				res_len = '0;
			end else if (q_cls.spa && q_cls.spb) begin
				res = 1'b1;
				if (flags.specials_equal || (dc == '0 && flags.specials_equal_at_start) ||
				    so == ORD_EQ) begin
					res_len = dc_inc;
				end else begin
					res_ord = so;
				end
			end else if (q_cls.spa) begin
				res     = 1'b1;
				res_ord = ORD_GT;
			end else if (q_cls.spb || q_cls.lt) begin
				res     = 1'b1;
				res_ord = ORD_LT;
			end else if (q_cls.gt) begin
				res     = 1'b1;
				res_ord = ORD_GT;
			end else if (dc_inc >= lim) begin
				// limit reached on an equal pair
				res     = 1'b1;
				res_len = dc_inc;
			end
			if (res)
				busy_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			depth_q     <= '0;
			limit_q     <= '0;
			sorder_q    <= ORD_LT;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= busy_n;
				if (active) begin
					depth_q  <= dc_inc;
					limit_q  <= lim;
					sorder_q <= so;
				end
			end
			if (q_pop && res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && res) begin
			order_q <= res_ord;
			plen_q  <= res_len;
		end
	end

	assign out_valid     = out_valid_q;
	assign order         = order_q;
	assign prefix_length = LEN_OUT_BITS'(plen_q);

	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && res) |=> !busy_q) else $error("busy after result");
	a_depth_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (depth_q < limit_q)) else $error("depth at or past limit while busy");
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !busy_q && !q_cls.first) |-> !res) else $error("result from idle request");

endmodule
`default_nettype wire
